[rtl/smpq_pkg.sv]
// ----------------------------------------------------------------------------
// smpq_pkg
// Shared types and codes for the sorted minimum priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

package smpq_pkg;

   localparam int DEFAULT_CAPACITY = 16;

   localparam logic [1:0] OP_ENQUEUE = 2'd0;
   localparam logic [1:0] OP_DEQUEUE = 2'd1;
   localparam logic [1:0] OP_PEEK    = 2'd2;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_UNDERFLOW = 2'd1;
   localparam logic [1:0] ST_OVERFLOW  = 2'd2;

   typedef struct packed {
      logic [1:0]         opcode;
      logic signed [31:0] value;
   } smpq_req_type;

   typedef struct packed {
      logic signed [31:0] front_value;
      logic [1:0]         status;
      logic [4:0]         occupancy;
   } smpq_rsp_type;

   // per-cycle command broadcast to every cell
   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_REMOVE
   } smpq_action_type;

   typedef struct packed {
      smpq_action_type    action;
      logic signed [31:0] value;
   } smpq_ctl_type;

   // what a cell shows its neighbors
   typedef struct packed {
      logic               valid;
      logic               gt;     // empty, or entry greater than the new value
      logic signed [31:0] entry;
   } smpq_link_type;

endpackage

`default_nettype wire

[rtl/sorted_min_priority_queue_unit.sv]
// A result word is registered and shows in the cycle after its request word is taken.
// Throughput: one word per cycle unless stalled; every cell compares against the new value
//   at once, so an insert or remove updates the whole cell chain together.
// A request is held off only while the result register is full and stalled.
// Reset (synchronous, active high) clears the count, the cell valid bits and the
//   result valid bit; stored entries and result data need no clearing.
// ----------------------------------------------------------------------------
// sorted_min_priority_queue_unit
// Sorted min priority queue built as a chain of compare-and-shift cells.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_min_priority_queue_unit #(
   parameter int CAPACITY = smpq_pkg::DEFAULT_CAPACITY
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire smpq_pkg::smpq_req_type req_word,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output smpq_pkg::smpq_rsp_type     rsp_word
);

   localparam int CW = $clog2(CAPACITY + 1);

   // Entry count; mirrors the number of valid cells.
   logic [CW-1:0] count_ff;
   logic [CW-1:0] count_in;

   // Result register.
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   smpq_pkg::smpq_rsp_type rsp_word_ff;
   smpq_pkg::smpq_rsp_type rsp_word_in;

   logic accept;
   logic empty;
   logic full;
   logic [31:0] count_wide;

   smpq_pkg::smpq_ctl_type  ctl;
   smpq_pkg::smpq_link_type links [CAPACITY];
   smpq_pkg::smpq_link_type head_link;
   smpq_pkg::smpq_link_type tail_link;
   logic [CAPACITY-1:0]     valid_vec;

   // Take a word unless the finished result cannot move on.
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   assign empty = (count_ff == '0);
   assign full  = (count_ff == CW'(CAPACITY));

   // Front of chain: always "smaller" so cell 0 takes the new value.
   assign head_link.valid = 1'b1;
   assign head_link.gt    = 1'b0;
   assign head_link.entry = '0;
   // Back of chain: nothing shifts in on removal.
   assign tail_link.valid = 1'b0;
   assign tail_link.gt    = 1'b1;
   assign tail_link.entry = '0;

   // Command for the cell chain.
   always_comb begin
      ctl.action = smpq_pkg::CELL_HOLD;
      ctl.value  = req_word.value;
      if (accept) begin
         case (req_word.opcode)
            smpq_pkg::OP_ENQUEUE: begin
               if (!full) ctl.action = smpq_pkg::CELL_INSERT;
            end
            smpq_pkg::OP_DEQUEUE: begin
               if (!empty) ctl.action = smpq_pkg::CELL_REMOVE;
            end
            default: begin
               ctl.action = smpq_pkg::CELL_HOLD;
            end
         endcase
      end
   end

   // The cell chain; each cell sees its left and right neighbor.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      smpq_pkg::smpq_link_type left_link;
      smpq_pkg::smpq_link_type right_link;

      if (i == 0) begin : g_first
         assign left_link = head_link;
      end else begin : g_mid_l
         assign left_link = links[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign right_link = tail_link;
      end else begin : g_mid_r
         assign right_link = links[i+1];
      end

      smpq_cell u_cell (
         .clock (clock),
         .reset (reset),
         .ctl   (ctl),
         .left  (left_link),
         .right (right_link),
         .link  (links[i])
      );

      assign valid_vec[i] = links[i].valid;
   end

   // Count update.
   always_comb begin
      count_in = count_ff;
      case (ctl.action)
         smpq_pkg::CELL_INSERT: count_in = count_ff + CW'(1);
         smpq_pkg::CELL_REMOVE: count_in = count_ff - CW'(1);
         default:               count_in = count_ff;
      endcase
   end

   assign count_wide = 32'(count_in);

   // Result word: a read's front comes from cell 0 before this cycle's shift; an enqueue echoes its value.
   always_comb begin
      rsp_word_in.front_value = '0;
      rsp_word_in.status      = smpq_pkg::ST_OK;
      rsp_word_in.occupancy   = count_wide[4:0];
      case (req_word.opcode)
         smpq_pkg::OP_ENQUEUE: begin
            rsp_word_in.front_value = req_word.value;
            if (full) rsp_word_in.status = smpq_pkg::ST_OVERFLOW;
         end
         smpq_pkg::OP_DEQUEUE, smpq_pkg::OP_PEEK: begin
            if (empty) begin
               rsp_word_in.status = smpq_pkg::ST_UNDERFLOW;
            end else begin
               rsp_word_in.front_value = links[0].entry;
            end
         end
         default: begin
            rsp_word_in.front_value = '0;
         end
      endcase
   end

   assign rsp_valid_in = accept | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

`ifndef SYNTH
   // Count tracks the number of occupied cells.
   a_count_matches_cells : assert property (@(posedge clock) disable iff (reset)
      $countones(valid_vec) == 32'(count_ff))
      else $error("entry count disagrees with cell valid bits");

   // Never more entries than cells.
   a_count_bounded : assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= CAPACITY)
      else $error("entry count above capacity");

   // Dequeue or peek on an empty queue reports underflow.
   a_underflow : assert property (@(posedge clock) disable iff (reset)
      (accept && empty && (req_word.opcode == smpq_pkg::OP_DEQUEUE ||
                           req_word.opcode == smpq_pkg::OP_PEEK))
      |=> (rsp_word.status == smpq_pkg::ST_UNDERFLOW))
      else $error("missing underflow status");
`endif

endmodule

`default_nettype wire

[rtl/smpq_cell.sv]
// ----------------------------------------------------------------------------
// smpq_cell
// One slot of the sorted chain: keeps, takes from left, takes the new value, or takes from right.
// ----------------------------------------------------------------------------
`default_nettype none

module smpq_cell (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire smpq_pkg::smpq_ctl_type  ctl,
   input  wire smpq_pkg::smpq_link_type left,
   input  wire smpq_pkg::smpq_link_type right,
   output smpq_pkg::smpq_link_type      link
);

   logic               valid_ff;
   logic               valid_in;
   logic signed [31:0] entry_ff;
   logic signed [31:0] entry_in;
   logic               gt;

   assign gt = !valid_ff || (entry_ff > ctl.value);

   always_comb begin
      valid_in = valid_ff;
      entry_in = entry_ff;
      case (ctl.action)
         smpq_pkg::CELL_INSERT: begin
            if (gt) begin
               valid_in = valid_ff | left.valid;
               entry_in = left.gt ? left.entry : ctl.value;
            end
         end
         smpq_pkg::CELL_REMOVE: begin
            valid_in = right.valid;
            entry_in = right.entry;
         end
         default: begin
            valid_in = valid_ff;
            entry_in = entry_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign link.valid = valid_ff;
   assign link.gt    = gt;
   assign link.entry = entry_ff;

endmodule

`default_nettype wire

[test/sorted_queue_monitor.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sorted_queue_monitor
// Watches both channels of the sorted min priority queue, keeps its own copy
// of the sorted contents, and checks every result word against it in order.
// ----------------------------------------------------------------------------

module sorted_queue_monitor #(
   parameter int CAPACITY = smpq_pkg::DEFAULT_CAPACITY
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_stall,
   input  smpq_pkg::smpq_req_type req_word,
   input  logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  smpq_pkg::smpq_rsp_type rsp_word,
   output int                     fail_count,
   output int                     words_in_flight
);

   logic signed [31:0]     sorted_vals [CAPACITY];
   int                     entry_total;
   smpq_pkg::smpq_rsp_type expected_rsp [$];

   initial begin
      fail_count = 0;
      words_in_flight = 0;
      entry_total = 0;
   end

   // applies one request word to the shadow queue and returns its result
   function automatic smpq_pkg::smpq_rsp_type apply_word(input smpq_pkg::smpq_req_type w);
      smpq_pkg::smpq_rsp_type r;
      int                     pos;
      r.front_value = '0;
      r.status      = smpq_pkg::ST_OK;
      case (w.opcode)
         smpq_pkg::OP_ENQUEUE: begin
            r.front_value = w.value;
            if (entry_total >= CAPACITY) begin
               r.status = smpq_pkg::ST_OVERFLOW;
            end else begin
               // new value goes after any equal ones
               pos = 0;
               while (pos < entry_total && !(sorted_vals[pos] > w.value))
                  pos++;
               for (int i = entry_total; i > pos; i--)
                  sorted_vals[i] = sorted_vals[i - 1];
               sorted_vals[pos] = w.value;
               entry_total++;
            end
         end
         smpq_pkg::OP_DEQUEUE, smpq_pkg::OP_PEEK: begin
            if (entry_total == 0) begin
               r.status = smpq_pkg::ST_UNDERFLOW;
            end else begin
               r.front_value = sorted_vals[0];
               if (w.opcode == smpq_pkg::OP_DEQUEUE) begin
                  for (int i = 1; i < entry_total; i++)
                     sorted_vals[i - 1] = sorted_vals[i];
                  entry_total--;
               end
            end
         end
         default: ;
      endcase
      r.occupancy = 5'(entry_total);
      return r;
   endfunction

   always @(posedge clock) begin
      smpq_pkg::smpq_rsp_type want;
      if (reset) begin
         entry_total = 0;
         expected_rsp.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsp.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("%0t: unexpected result word front %0d status %0d occ %0d",
                           $realtime, rsp_word.front_value, rsp_word.status,
                           rsp_word.occupancy);
            end else begin
               want = expected_rsp.pop_front();
               if (rsp_word.front_value !== want.front_value ||
                   rsp_word.status !== want.status ||
                   rsp_word.occupancy !== want.occupancy) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("%0t: mismatch front %0d/%0d status %0d/%0d occ %0d/%0d (exp/act)",
                              $realtime,
                              want.front_value, rsp_word.front_value,
                              want.status, rsp_word.status,
                              want.occupancy, rsp_word.occupancy);
               end
            end
         end
         if (req_valid && !req_stall)
            expected_rsp.push_back(apply_word(req_word));
      end
      words_in_flight = expected_rsp.size();
   end

endmodule

[test/sorted_min_priority_queue_unit_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sorted_min_priority_queue_unit_tb
// Drives request words into the sorted min priority queue and applies random
// back-pressure to its results; a monitor beside the block predicts and checks.
// ----------------------------------------------------------------------------

module sorted_min_priority_queue_unit_tb;

   localparam int         CAPACITY     = smpq_pkg::DEFAULT_CAPACITY;
   localparam logic [1:0] OP_UNUSED    = 2'd3;   // leaves the queue unchanged
   localparam int         RANDOM_WORDS = 2000;
   localparam int         HOLD_AT      = 300;    // result side freezes here
   localparam int         HOLD_CYCLES  = 80;
   localparam int         PAUSE_AT     = 1000;   // request side drains here

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   smpq_pkg::smpq_req_type req_word  = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   smpq_pkg::smpq_rsp_type rsp_word;

   int fail_count;
   int words_in_flight;

   // handshake between the request and result processes for the long hold
   bit hold_wanted = 1'b0;
   bit hold_done   = 1'b0;
   // set per block of request words: no gaps at all for a while
   bit gaps_off    = 1'b0;

   always #1 clock = ~clock;

   sorted_min_priority_queue_unit #(
      .CAPACITY(CAPACITY)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_word (req_word),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_word (rsp_word)
   );

   sorted_queue_monitor #(
      .CAPACITY(CAPACITY)
   ) u_monitor (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_word       (req_word),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_word       (rsp_word),
      .fail_count     (fail_count),
      .words_in_flight(words_in_flight)
   );

   // idle length: mostly none, sometimes a few cycles, rarely a long one
   function automatic int pick_idle();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70)
         return 0;
      else if (r < 95)
         return $urandom_range(1, 3);
      else
         return $urandom_range(8, 40);
   endfunction

   // value mix: full range for bit coverage, a narrow band to force
   // duplicates, and the signed extremes
   function automatic logic signed [31:0] pick_value();
      logic signed [31:0] v;
      case ($urandom_range(0, 9))
         5, 6, 7: v = int'($urandom_range(0, 8)) - 4;
         8: begin
            case ($urandom_range(0, 5))
               0: v = 32'sh7fff_ffff;
               1: v = 32'sh8000_0000;
               2: v = 32'sh7fff_fffe;
               3: v = 32'sh8000_0001;
               4: v = '0;
               default: v = -1;
            endcase
         end
         default: v = $urandom;
      endcase
      return v;
   endfunction

   // offer one request word at the falling edge and hold it until taken;
   // returns at the falling edge after the accepting rising edge
   task automatic send_word(input logic [1:0] op, input logic signed [31:0] val);
      int gap;
      gap = (gaps_off || (hold_wanted && !hold_done)) ? 0 : pick_idle();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_word  <= '{opcode: op, value: val};
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   // result side back-pressure, in its own process
   initial begin
      int len;
      @(negedge clock);
      forever begin
         if (hold_wanted && !hold_done) begin
            // long freeze while the sender keeps offering: the result register
            // fills and the block has to stall its input
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_done = 1'b1;
         end else begin
            if ($urandom_range(0, 99) < 10) begin
               rsp_stall <= 1'b0;      // clean stretch, no stalls
               len = 50;
            end else begin
               rsp_stall <= ($urandom_range(0, 2) == 0);
               len = pick_idle() + 1;
            end
            repeat (len) @(negedge clock);
         end
      end
   end

   // request side: directed words, then random blocks, then the verdict
   initial begin
      int         sent;
      int         block_left;
      int         enq_pct;
      int         deq_pct;
      int         r;
      logic [1:0] op;

      repeat (2) @(negedge clock);
      reset <= 1'b0;

      // empty queue: underflow on both reads, unused opcode leaves it unchanged
      send_word(smpq_pkg::OP_PEEK, 32'sd5);
      send_word(smpq_pkg::OP_DEQUEUE, -32'sd1);
      send_word(OP_UNUSED, 32'sh7fff_ffff);
      // signed extremes plus a duplicate zero
      send_word(smpq_pkg::OP_ENQUEUE, 32'sh7fff_ffff);
      send_word(smpq_pkg::OP_ENQUEUE, 32'sh8000_0000);
      send_word(smpq_pkg::OP_ENQUEUE, 32'sd0);
      send_word(smpq_pkg::OP_ENQUEUE, -32'sd1);
      send_word(smpq_pkg::OP_ENQUEUE, 32'sd0);
      send_word(smpq_pkg::OP_PEEK, '0);
      send_word(OP_UNUSED, 32'sh8000_0000);
      // fill to capacity, then one more to hit overflow
      for (int i = 0; i < CAPACITY - 5; i++)
         send_word(smpq_pkg::OP_ENQUEUE, 32'(i * 7 - 30));
      send_word(smpq_pkg::OP_ENQUEUE, 32'sh1234_5678);
      send_word(smpq_pkg::OP_PEEK, '0);
      send_word(smpq_pkg::OP_DEQUEUE, '0);
      send_word(smpq_pkg::OP_DEQUEUE, '0);

      // random blocks, each biased toward filling, draining or mixing so the
      // queue keeps crossing both the empty and the full boundary
      sent       = 0;
      block_left = 0;
      enq_pct    = 0;
      deq_pct    = 0;
      while (sent < RANDOM_WORDS) begin
         if (block_left == 0) begin
            block_left = $urandom_range(20, 60);
            case ($urandom_range(0, 2))
               0:       begin enq_pct = 75; deq_pct = 15; end
               1:       begin enq_pct = 20; deq_pct = 60; end
               default: begin enq_pct = 45; deq_pct = 35; end
            endcase
            gaps_off = ($urandom_range(0, 4) == 0);
         end
         if (sent == HOLD_AT)
            hold_wanted = 1'b1;
         if (sent == PAUSE_AT) begin
            // sender goes quiet until every result is back
            req_valid <= 1'b0;
            do @(negedge clock); while (words_in_flight != 0);
         end
         r = $urandom_range(0, 99);
         if (r < 4)
            op = OP_UNUSED;
         else if (r < 4 + enq_pct)
            op = smpq_pkg::OP_ENQUEUE;
         else if (r < 4 + enq_pct + deq_pct)
            op = smpq_pkg::OP_DEQUEUE;
         else
            op = smpq_pkg::OP_PEEK;
         send_word(op, pick_value());
         sent++;
         block_left--;
      end

      req_valid <= 1'b0;
      do @(negedge clock); while (words_in_flight != 0);
      repeat (4) @(negedge clock);

      if (fail_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   // run limit, several times the slowest legal run
   initial begin
      #2_000_000;
      $display("simulation failed");
      $finish;
   end

endmodule
